>>> rtl/segmented_delta_elias_encoder_top_macros.svh
// Assertion macros for the segmented delta Elias encoder.
`ifndef SEGMENTED_DELTA_ELIAS_ENCODER_TOP_MACROS_SVH
`define SEGMENTED_DELTA_ELIAS_ENCODER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SDE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define SDE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/sde_pkg.sv
// Shared types, constants and the Elias delta code function of the encoder.
`timescale 1ns / 1ps

package sde_pkg;

	localparam int WORD_W   = 64;
	localparam int UPPER_W  = 32;
	localparam int SEG_W    = 12;
	localparam int VAL_W    = SEG_W + 1;
	localparam int CODE_W   = 20;
	localparam int LEN_W    = 5;
	localparam int IDX_W    = 2;
	localparam int NUM_SEG  = 3;
	localparam int QDEPTH   = 2;
	localparam int QPTR_W   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W   = $clog2(QDEPTH + 1);

	// Configuration register indexes
	localparam logic REG_SEGMENT_MODE = 1'b0;
	localparam logic REG_USE_XOR      = 1'b1;

	// Segment modes; the unused code behaves as one segment
	localparam logic [1:0] SEG_MODE_ONE     = 2'd0;
	localparam logic [1:0] SEG_MODE_12_12_8 = 2'd1;
	localparam logic [1:0] SEG_MODE_12_8_8  = 2'd2;

	localparam logic [IDX_W-1:0] LAST_SEG_IDX = IDX_W'(NUM_SEG - 1);

	typedef struct packed {
		logic [1:0] segment_mode;
		logic       use_xor;
	} cfg_t;

	typedef struct packed {
		logic [NUM_SEG-1:0][SEG_W-1:0] cur;
		logic [NUM_SEG-1:0][SEG_W-1:0] prv;
		logic                          use_xor;
		logic                          three;
	} seg_job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef struct packed {
		logic [CODE_W-1:0] bits;
		logic [LEN_W-1:0]  length;
	} code_t;

	// Elias delta code of v (1..4096), with an optional leading sign bit
	function automatic code_t delta_code(logic [VAL_W-1:0] v, logic neg);
		logic [3:0]        n;
		logic [2:0]        l;
		logic [CODE_W-1:0] mask;
		code_t             res;
		n = '0;
		for (int i = 0; i < VAL_W; i++) begin
			if (v[i]) begin
				n = 4'(i + 1);
			end
		end
		l = n[3] ? 3'd4 : (n[2] ? 3'd3 : (n[1] ? 3'd2 : 3'd1));
		mask = (CODE_W'(1) << (n - 4'd1)) - CODE_W'(1);
		res.bits = (CODE_W'(n) << (n - 4'd1)) | (CODE_W'(v) & mask);
		res.length = LEN_W'({l, 1'b0}) + LEN_W'(n) - LEN_W'(2);
		if (neg) begin
			res.bits = res.bits | (CODE_W'(1) << res.length);
			res.length = res.length + LEN_W'(1);
		end
		return res;
	endfunction

endpackage

>>> rtl/sde_channels.sv
// Valid/ready channel interfaces for input words and segment codes.
`timescale 1ns / 1ps

interface sde_word_if;
	logic                       valid;
	logic                       ready;
	logic [sde_pkg::WORD_W-1:0] word;

	modport source (output valid, output word, input ready);
	modport sink (input valid, input word, output ready);
endinterface

interface sde_code_if;
	logic                       valid;
	logic                       ready;
	logic [sde_pkg::CODE_W-1:0] code_bits;
	logic [sde_pkg::LEN_W-1:0]  code_length;
	logic [sde_pkg::IDX_W-1:0]  segment_index;
	logic                       last_segment;

	modport source (output valid, output code_bits, output code_length,
		output segment_index, output last_segment, input ready);
	modport sink (input valid, input code_bits, input code_length,
		input segment_index, input last_segment, output ready);
endinterface

>>> rtl/sde_front.sv
// Front end: accepts words, splits them into segments against the previous word.
`timescale 1ns / 1ps

module sde_front (
	input  logic              clk,
	input  logic              arst_n,
	input  sde_pkg::cfg_t     cfg,
	sde_word_if.sink          word_ch,
	input  sde_pkg::q_stat_t  q_stat,
	output logic              push,
	output sde_pkg::seg_job_t push_job
);

	logic [sde_pkg::UPPER_W-1:0] prev_upper_q;
	logic                        first_q;
	logic [sde_pkg::UPPER_W-1:0] cur_u;
	logic [sde_pkg::UPPER_W-1:0] prv_u;
	logic                        accept;

	assign word_ch.ready = !q_stat.full;
	assign accept = word_ch.valid && word_ch.ready;
	assign push = accept;

	assign cur_u = word_ch.word[sde_pkg::WORD_W-1 -: sde_pkg::UPPER_W];
	// The first word is compared against zero
	assign prv_u = first_q ? '0 : prev_upper_q;

	always_comb begin
		push_job.three = (cfg.segment_mode == sde_pkg::SEG_MODE_12_12_8) ||
			(cfg.segment_mode == sde_pkg::SEG_MODE_12_8_8);
		push_job.use_xor = !first_q && cfg.use_xor;
		push_job.cur[0] = cur_u[31:20];
		push_job.prv[0] = prv_u[31:20];
		if (cfg.segment_mode == sde_pkg::SEG_MODE_12_12_8) begin
			push_job.cur[1] = cur_u[19:8];
			push_job.prv[1] = prv_u[19:8];
			push_job.cur[2] = {4'b0, cur_u[7:0]};
			push_job.prv[2] = {4'b0, prv_u[7:0]};
		end else begin
			push_job.cur[1] = {4'b0, cur_u[19:12]};
			push_job.prv[1] = {4'b0, prv_u[19:12]};
			push_job.cur[2] = {4'b0, cur_u[11:4]};
			push_job.prv[2] = {4'b0, prv_u[11:4]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_upper_q <= '0;
			first_q <= 1'b1;
		end else if (accept) begin
			prev_upper_q <= cur_u;
			first_q <= 1'b0;
		end
	end

endmodule

>>> rtl/sde_queue.sv
// Short job queue between the front and the back end.
`timescale 1ns / 1ps

module sde_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  sde_pkg::seg_job_t push_job,
	input  logic              pop,
	output sde_pkg::seg_job_t pop_job,
	output sde_pkg::q_stat_t  q_stat
);

	sde_pkg::seg_job_t                job_q [sde_pkg::QDEPTH];
	logic [sde_pkg::QPTR_W-1:0]       wr_ptr_q;
	logic [sde_pkg::QPTR_W-1:0]       rd_ptr_q;
	logic [sde_pkg::QCNT_W-1:0]       cnt_q;
	logic                             do_push;
	logic                             do_pop;

	function automatic logic [sde_pkg::QPTR_W-1:0] next_ptr(logic [sde_pkg::QPTR_W-1:0] p);
		return (p == sde_pkg::QPTR_W'(sde_pkg::QDEPTH - 1)) ? '0 : p + sde_pkg::QPTR_W'(1);
	endfunction

	assign q_stat.full  = (cnt_q == sde_pkg::QCNT_W'(sde_pkg::QDEPTH));
	assign q_stat.empty = (cnt_q == '0);
	assign do_push = push && !q_stat.full;
	assign do_pop  = pop && !q_stat.empty;
	assign pop_job = job_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			job_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + sde_pkg::QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - sde_pkg::QCNT_W'(1);
			end
		end
	end

endmodule

>>> rtl/sde_back.sv
// Back end: codes one segment a cycle, while a job is queued and the output can take it, into the output register.
`timescale 1ns / 1ps

module sde_back (
	input  logic              clk,
	input  logic              arst_n,
	input  sde_pkg::seg_job_t job,
	input  sde_pkg::q_stat_t  q_stat,
	output logic              pop,
	sde_code_if.source        code_ch
);

	logic [sde_pkg::IDX_W-1:0] seg_q;
	logic                      valid_q;
	logic [sde_pkg::CODE_W-1:0] bits_q;
	logic [sde_pkg::LEN_W-1:0]  len_q;
	logic [sde_pkg::IDX_W-1:0]  idx_q;
	logic                       last_q;
	logic [sde_pkg::SEG_W-1:0]  q;
	logic [sde_pkg::SEG_W-1:0]  p;
	logic [sde_pkg::VAL_W-1:0]  v;
	logic                       neg;
	logic                       last;
	logic                       load;
	sde_pkg::code_t             code;

	always_comb begin
		case (seg_q)
			2'd1: begin
				q = job.cur[1];
				p = job.prv[1];
			end
			2'd2: begin
				q = job.cur[2];
				p = job.prv[2];
			end
			default: begin
				q = job.cur[0];
				p = job.prv[0];
			end
		endcase
	end

	always_comb begin
		if (job.use_xor) begin
			v = sde_pkg::VAL_W'(q ^ p) + sde_pkg::VAL_W'(1);
			neg = 1'b0;
		end else if (q > p) begin
			v = sde_pkg::VAL_W'(q - p) + sde_pkg::VAL_W'(1);
			neg = 1'b0;
		end else begin
			// zero or negative gap: code the magnitude behind a leading one
			v = sde_pkg::VAL_W'(p - q) + sde_pkg::VAL_W'(1);
			neg = 1'b1;
		end
	end

	assign code = sde_pkg::delta_code(v, neg);
	assign last = !job.three || (seg_q == sde_pkg::LAST_SEG_IDX);
	assign load = !q_stat.empty && (!valid_q || code_ch.ready);
	assign pop  = load && last;

	always_ff @(posedge clk) begin
		if (load) begin
			bits_q <= code.bits;
			len_q <= code.length;
			idx_q <= seg_q;
			last_q <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			seg_q <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
			end else if (code_ch.ready) begin
				valid_q <= 1'b0;
			end
			if (load) begin
				seg_q <= last ? '0 : seg_q + sde_pkg::IDX_W'(1);
			end
		end
	end

	assign code_ch.valid = valid_q;
	assign code_ch.code_bits = bits_q;
	assign code_ch.code_length = len_q;
	assign code_ch.segment_index = idx_q;
	assign code_ch.last_segment = last_q;

endmodule

>>> rtl/segmented_delta_elias_encoder_top.sv
// Top level of the segmented delta Elias encoder.
//
//  channel   dir  payload                                              handshake
//  word_ch   in   word[63:0]                                           valid/ready
//  code_ch   out  code_bits[19:0] code_length[4:0] segment_index[1:0]  valid/ready
//                 last_segment
//  cfg       in   cfg_index[0] cfg_data[1:0]                           cfg_we, no wait
//
// One segment code leaves per cycle while a job is queued and code_ch is ready: a word
// gives one code in segment mode 0 and the unused mode, three in the three-segment modes,
// all from the single coding unit in the back end. A word is taken every cycle while the
// two-entry job queue has room; a code passes the job queue and then the output register.
// No clearing pass after reset. A stalled output holds its code while the front keeps filling the queue.
`timescale 1ns / 1ps
`include "segmented_delta_elias_encoder_top_macros.svh"

module segmented_delta_elias_encoder_top (
	input  logic       clk,
	input  logic       arst_n,
	sde_word_if.sink   word_ch,
	sde_code_if.source code_ch,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [1:0] cfg_data
);

	sde_pkg::cfg_t     cfg_q;
	sde_pkg::q_stat_t  q_stat;
	sde_pkg::seg_job_t push_job;
	sde_pkg::seg_job_t pop_job;
	logic              push;
	logic              pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.segment_mode <= sde_pkg::SEG_MODE_ONE;
			cfg_q.use_xor <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sde_pkg::REG_SEGMENT_MODE: cfg_q.segment_mode <= cfg_data;
				sde_pkg::REG_USE_XOR:      cfg_q.use_xor <= cfg_data[0];
			endcase
		end
	end

	sde_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.word_ch  (word_ch),
		.q_stat   (q_stat),
		.push     (push),
		.push_job (push_job)
	);

	sde_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.pop_job  (pop_job),
		.q_stat   (q_stat)
	);

	sde_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.job     (pop_job),
		.q_stat  (q_stat),
		.pop     (pop),
		.code_ch (code_ch)
	);

	`SDE_ASSERT_NOW(a_final_seg_last, clk, arst_n, code_ch.valid && (code_ch.segment_index == sde_pkg::LAST_SEG_IDX), code_ch.last_segment, "third segment not marked last")
	`SDE_ASSERT_NOW(a_bits_fit, clk, arst_n, code_ch.valid, (code_ch.code_length != 5'd0) && ((code_ch.code_bits >> code_ch.code_length) == 20'd0), "code bits exceed code length")
	`SDE_ASSERT_NEXT(a_next_seg, clk, arst_n, code_ch.valid && code_ch.ready && !code_ch.last_segment, code_ch.valid && (code_ch.segment_index != 2'd0), "next segment of a word not presented")

endmodule
